// ===== hdl/qpyu_pkg.sv =====
// package with word types, sequencer states, constants and the arctangent table
`timescale 1ns / 1ps
package qpyu_pkg;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_word_type;

   typedef struct packed {
      logic signed [14:0] pitch_rad;
      logic signed [31:0] yaw_continuous;
      logic               pitch_clamped;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQ,
      ST_SQRT_WAIT,
      ST_PITCH_GO,
      ST_PITCH_WAIT,
      ST_YAW_GO,
      ST_YAW_WAIT,
      ST_ACC,
      ST_OUT
   } state_type;

   localparam int TERM_W = 36;   // sums of products, Q.28
   localparam int ANG_W  = 28;   // cordic angle, 2^-24 rad
   localparam int CRD_W  = 38;   // cordic x / y datapath
   localparam int MUL_W  = 30;   // multiplier operand width
   localparam int RAD_W  = 57;   // square root radicand

   localparam logic signed [ANG_W-1:0] HALF_PI_A24 = 28'sd26353589;
   localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;
   localparam logic signed [17:0] THREE_Q13   = 18'sd24576;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [TERM_W-1:0] ONE_Q28 = 36'sd268435456;

   function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 28'd13176795;
         5'd1:    v = 28'd7778716;
         5'd2:    v = 28'd4110060;
         5'd3:    v = 28'd2086331;
         5'd4:    v = 28'd1047214;
         5'd5:    v = 28'd524117;
         5'd6:    v = 28'd262123;
         5'd7:    v = 28'd131069;
         5'd8:    v = 28'd65536;
         5'd9:    v = 28'd32768;
         5'd10:   v = 28'd16384;
         5'd11:   v = 28'd8192;
         5'd12:   v = 28'd4096;
         5'd13:   v = 28'd2048;
         5'd14:   v = 28'd1024;
         5'd15:   v = 28'd512;
         5'd16:   v = 28'd256;
         5'd17:   v = 28'd128;
         5'd18:   v = 28'd64;
         5'd19:   v = 28'd32;
         5'd20:   v = 28'd16;
         5'd21:   v = 28'd8;
         5'd22:   v = 28'd4;
         5'd23:   v = 28'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/qpyu_isqrt.sv =====
// bit-pair serial floor square root of the cosine radicand
`timescale 1ns / 1ps
module qpyu_isqrt
   import qpyu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [28:0]      root
);

   logic [RAD_W-1:0] n_ff, n_in;
   logic [RAD_W:0]   r_ff, r_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W:0]   trial;

   assign trial = r_ff + {1'b0, bit_ff};

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         r_in    = '0;
         bit_in  = {1'b1, {(RAD_W-1){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in = n_ff - trial[RAD_W-1:0];
            r_in = (r_ff >> 1) + {1'b0, bit_ff};
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[28:0];

endmodule

// ===== hdl/qpyu_cordic.sv =====
// iterative vectoring cordic, atan2 rounded to q3.13
`timescale 1ns / 1ps
module qpyu_cordic
   import qpyu_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [TERM_W-1:0] y_in,
   input  logic signed [TERM_W-1:0] x_in,
   output logic                     done,
   output logic signed [15:0]       angle
);

   localparam int IW = $clog2(STEPS);

   logic signed [CRD_W-1:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic [IW-1:0]           i_ff, i_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [CRD_W-1:0] xe, ye, xs, ys;
   logic [ANG_W-1:0]        tab;
   logic signed [ANG_W-1:0] rnd;

   assign xe  = CRD_W'(x_in);
   assign ye  = CRD_W'(y_in);
   assign xs  = x_ff >>> i_ff;
   assign ys  = y_ff >>> i_ff;
   assign tab = atan_entry(5'(i_ff));

   always_comb begin
      x_in_r  = x_ff;
      y_in_r  = y_ff;
      ang_in  = ang_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         i_in    = '0;
         busy_in = 1'b1;
         if (xe < 0) begin
            if (ye >= 0) begin
               x_in_r = ye;
               y_in_r = -xe;
               ang_in = HALF_PI_A24;
            end else begin
               x_in_r = -ye;
               y_in_r = xe;
               ang_in = -HALF_PI_A24;
            end
         end else begin
            x_in_r = xe;
            y_in_r = ye;
            ang_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_r = x_ff + ys;
            y_in_r = y_ff - xs;
            ang_in = ang_ff + $signed(tab);
         end else if (y_ff < 0) begin
            x_in_r = x_ff - ys;
            y_in_r = y_ff + xs;
            ang_in = ang_ff - $signed(tab);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_r;
      y_ff   <= y_in_r;
      ang_ff <= ang_in;
      i_ff   <= i_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rnd   = ang_ff + 28'sd1024;
   assign done  = done_ff;
   assign angle = rnd[26:11];

endmodule

// ===== hdl/quaternion_pitch_yaw_unwrap_core.sv =====
// top level: quaternion to pitch and unwrapped continuous yaw
`timescale 1ns / 1ps
// one word in gives pitch = asin(2(wy - zx)) and yaw = atan2(2(wz + xy), 1 - 2(y^2 + z^2)),
// in radians, pitch q2.13 and yaw q3.13; the yaw step is unwrapped by 2pi beyond +-3 rad
// and summed into a saturating 32-bit accumulator reported as yaw_continuous. a single
// 30x30 multiplier forms the six quaternion products and s*s, a bit-pair square root
// (29 iterations) gives the pitch cosine, and one shared vectoring cordic runs atan2 twice
// for an unclamped word and once for a clamped one (each a start, CORDIC_STEPS iterations
// and a done step). a new word is taken only after the result is registered, which waits on
// rsp_ready while an earlier one is pending; req_ready is high only between words. with
// the enable register clear, accepted words are dropped without result or state change.
module quaternion_pitch_yaw_unwrap_core
   import qpyu_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   state_type state_ff, state_in;

   // control
   logic                     enable_ff;
   logic [2:0]               cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_ff, rsp_in;

   // captured word and arithmetic
   req_word_type             q_ff, q_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [2*MUL_W-1:0] p_ff;
   logic signed [TERM_W-1:0] acc_s_ff, acc_s_in;   // wy - zx
   logic signed [TERM_W-1:0] acc_y_ff, acc_y_in;   // wz + xy
   logic signed [TERM_W-1:0] acc_c_ff, acc_c_in;   // y^2 + z^2
   logic signed [TERM_W-1:0] s_term, sy_term, cy_term, p_term;
   logic                     clamp;

   // results and state
   logic signed [14:0]       pitch_ff, pitch_in;
   logic                     clamped_ff, clamped_in;
   logic signed [15:0]       yaw_ff, yaw_in;
   logic signed [15:0]       prev_ff, prev_in;
   logic signed [31:0]       acc_ff, acc_in;
   logic signed [17:0]       dyaw_raw, dyaw_a, dyaw;
   logic signed [33:0]       acc_sum;

   // shared units
   logic                     sqrt_start, sqrt_done;
   logic [RAD_W-1:0]         radicand;
   logic [28:0]              root;
   logic                     crd_start, crd_done;
   logic signed [TERM_W-1:0] crd_y, crd_x;
   logic signed [15:0]       crd_angle;

   assign s_term  = acc_s_ff <<< 1;
   assign sy_term = acc_y_ff <<< 1;
   assign cy_term = ONE_Q28 - (acc_c_ff <<< 1);
   assign p_term  = TERM_W'(p_ff);
   assign clamp   = (s_term >= ONE_Q28) || (s_term <= -ONE_Q28);

   // one multiplier, product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (cnt_ff)
            3'd0: begin mul_a = MUL_W'(q_ff.quat_w); mul_b = MUL_W'(q_ff.quat_y); end
            3'd1: begin mul_a = MUL_W'(q_ff.quat_z); mul_b = MUL_W'(q_ff.quat_x); end
            3'd2: begin mul_a = MUL_W'(q_ff.quat_w); mul_b = MUL_W'(q_ff.quat_z); end
            3'd3: begin mul_a = MUL_W'(q_ff.quat_x); mul_b = MUL_W'(q_ff.quat_y); end
            3'd4: begin mul_a = MUL_W'(q_ff.quat_y); mul_b = MUL_W'(q_ff.quat_y); end
            3'd5: begin mul_a = MUL_W'(q_ff.quat_z); mul_b = MUL_W'(q_ff.quat_z); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQ) begin
         // unless clamped, |s| < 1.0 here, so it fits the operand width
         mul_a = MUL_W'(s_term);
         mul_b = MUL_W'(s_term);
      end
   end

   // radicand 2^56 - s*s
   assign radicand   = {1'b1, {(RAD_W-1){1'b0}}} - RAD_W'(p_ff);
   assign sqrt_start = (state_ff == ST_SQ) && (cnt_ff == 3'd1);

   assign crd_start = (state_ff == ST_PITCH_GO) || (state_ff == ST_YAW_GO);
   assign crd_y     = (state_ff == ST_PITCH_GO) ? s_term : sy_term;
   assign crd_x     = (state_ff == ST_PITCH_GO) ? TERM_W'({1'b0, root}) : cy_term;

   // unwrap and saturating accumulate
   assign dyaw_raw = 18'(yaw_ff) - 18'(prev_ff);
   assign dyaw_a   = (dyaw_raw > THREE_Q13) ? dyaw_raw - TWO_PI_Q13 : dyaw_raw;
   assign dyaw     = (dyaw_a < -THREE_Q13) ? dyaw_a + TWO_PI_Q13 : dyaw_a;
   assign acc_sum  = 34'(acc_ff) + 34'(dyaw);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid && enable_ff) state_in = ST_MUL;
         ST_MUL:        if (cnt_ff == 3'd6) state_in = ST_SQ;
         ST_SQ:         if (clamp) state_in = ST_YAW_GO;
                        else if (cnt_ff == 3'd1) state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT:  if (sqrt_done) state_in = ST_PITCH_GO;
         ST_PITCH_GO:   state_in = ST_PITCH_WAIT;
         ST_PITCH_WAIT: if (crd_done) state_in = ST_YAW_GO;
         ST_YAW_GO:     state_in = ST_YAW_WAIT;
         ST_YAW_WAIT:   if (crd_done) state_in = ST_ACC;
         ST_ACC:        state_in = ST_OUT;
         ST_OUT:        if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      acc_s_in     = acc_s_ff;
      acc_y_in     = acc_y_ff;
      acc_c_in     = acc_c_ff;
      pitch_in     = pitch_ff;
      clamped_in   = clamped_ff;
      yaw_in       = yaw_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            q_in   = req_data;
            cnt_in = '0;
         end
         ST_MUL: begin
            cnt_in = (cnt_ff == 3'd6) ? 3'd0 : cnt_ff + 3'd1;
            case (cnt_ff)
               3'd1: acc_s_in = p_term;
               3'd2: acc_s_in = acc_s_ff - p_term;
               3'd3: acc_y_in = p_term;
               3'd4: acc_y_in = acc_y_ff + p_term;
               3'd5: acc_c_in = p_term;
               3'd6: acc_c_in = acc_c_ff + p_term;
               default: ;
            endcase
         end
         ST_SQ: begin
            cnt_in     = cnt_ff + 3'd1;
            clamped_in = clamp;
            if (clamp) pitch_in = s_term[TERM_W-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
         end
         ST_PITCH_WAIT: if (crd_done) pitch_in = crd_angle[14:0];
         ST_YAW_WAIT:   if (crd_done) yaw_in = crd_angle;
         ST_ACC: begin
            prev_in = yaw_ff;
            if (acc_sum > 34'sd2147483647)       acc_in = 32'sh7FFFFFFF;
            else if (acc_sum < -34'sd2147483648) acc_in = 32'sh80000000;
            else                                 acc_in = acc_sum[31:0];
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pitch_rad      = pitch_ff;
               rsp_in.yaw_continuous = acc_ff;
               rsp_in.pitch_clamped  = clamped_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      p_ff       <= mul_a * mul_b;
      acc_s_ff   <= acc_s_in;
      acc_y_ff   <= acc_y_in;
      acc_c_ff   <= acc_c_in;
      pitch_ff   <= pitch_in;
      clamped_ff <= clamped_in;
      yaw_ff     <= yaw_in;
      rsp_ff     <= rsp_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         acc_ff       <= acc_in;
         if (csr_wr_en) enable_ff <= csr_wr_data;
      end
   end

   qpyu_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   qpyu_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (crd_start),
      .y_in  (crd_y),
      .x_in  (crd_x),
      .done  (crd_done),
      .angle (crd_angle)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a clamped pitch is exactly plus or minus pi/2
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pitch_clamped |->
         (rsp_data.pitch_rad == HALF_PI_Q13) || (rsp_data.pitch_rad == -HALF_PI_Q13))
      else $error("clamped pitch not at pi/2");

   // pitch never leaves +-pi/2
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pitch_rad <= HALF_PI_Q13) &&
                    (rsp_data.pitch_rad >= -HALF_PI_Q13))
      else $error("pitch out of range");

   // yaw state moves only in the accumulate step
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACC) |=> $stable(prev_ff) && $stable(acc_ff))
      else $error("yaw state changed outside accumulate");

endmodule
